[rtl/sit_pkg.sv]
`default_nettype none

package sit_pkg;

  // Default number of slots in the table
  localparam int DEF_CAPACITY = 16;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic                       action;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    status_t                    status;
    logic [COUNT_W-1:0]         entry_count;
    logic signed [VALUE_W-1:0]  smallest_value;
  } rsp_t;

  // Operation broadcast to every cell of the row
  typedef struct packed {
    logic                       ins;    // insert goes ahead
    logic                       del;    // delete found its value
    logic signed [VALUE_W-1:0]  value;
  } cell_op_t;

  // What a cell hands to its neighbors
  typedef struct packed {
    logic                       lt;     // occupied and holds less than the key
    logic signed [VALUE_W-1:0]  slot;
  } cell_link_t;

endpackage

`default_nettype wire

[rtl/sit_cell.sv]
`default_nettype none

module sit_cell
  import sit_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire cell_op_t                  op,
  input  wire logic                      occupied,
  input  wire cell_link_t                left,
  input  wire logic signed [VALUE_W-1:0] right_slot,
  output      cell_link_t                link,
  output      logic                      eq,
  output      logic signed [VALUE_W-1:0] slot_next
);

  logic signed [VALUE_W-1:0] slot;

  // Compare against the broadcast key
  assign link.lt   = occupied && (slot < op.value);
  assign link.slot = slot;
  assign eq        = occupied && (slot == op.value);

  // Smaller entries stay; the rest shift right on insert, left on delete
  always_comb begin
    slot_next = slot;
    if (op.ins && !link.lt) begin
      slot_next = left.lt ? op.value : left.slot;
    end else if (op.del && !link.lt) begin
      slot_next = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= slot_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sorted_integer_table_top.sv]
`default_nettype none

// Sorted integer table: keeps up to CAPACITY signed 32-bit values in
// ascending order (duplicates allowed) in a row of compare-and-shift cells.
// Each cmd transaction inserts its value at its sorted place or deletes one
// occurrence of it, and yields one rsp transaction with the status, the
// entry count after the operation and the smallest value held (zero when
// empty). All cells compare the broadcast key and shift together; a new
// cmd is taken every cycle while the rsp register is free or being drained;
// the response is registered and appears in the cycle after acceptance.
// Insert into a full table is refused with status full; entry_count carries
// the low five bits of the count.
module sorted_integer_table_top
  import sit_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output      logic cmd_ready,
  input  wire cmd_t cmd,
  output      logic rsp_valid,
  input  wire logic rsp_ready,
  output      rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic                       accept;
  logic                       full;
  logic                       found;
  logic                       load;
  status_t                    status;
  cell_op_t                   op;
  cell_link_t                 link   [CAPACITY];
  logic                       eq     [CAPACITY];
  logic [CAPACITY-1:0]        hit;
  logic signed [VALUE_W-1:0]  nxt    [CAPACITY];
  logic [CNT_W+COUNT_W-1:0]   count_ext;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign found     = |hit;

  // Operation seen by the cells
  assign op.ins   = (cmd.action == ACT_INSERT) && !full;
  assign op.del   = (cmd.action == ACT_DELETE) && found;
  assign op.value = cmd.value;
  assign load     = accept && (op.ins || op.del);

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t                left;
    logic signed [VALUE_W-1:0] right_slot;

    if (i == 0) begin : g_head
      assign left.lt   = 1'b1;
      assign left.slot = link[i].slot;
    end else begin : g_body
      assign left = link[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_slot = link[i].slot;
    end else begin : g_mid
      assign right_slot = link[i+1].slot;
    end

    // First entry not below the key is an exact match
    assign hit[i] = eq[i] && left.lt;

    sit_cell u_cell (
      .clk        (clk),
      .load       (load),
      .op         (op),
      .occupied   (count > CNT_W'(i)),
      .left       (left),
      .right_slot (right_slot),
      .link       (link[i]),
      .eq         (eq[i]),
      .slot_next  (nxt[i])
    );
  end

  // Status and new count
  always_comb begin
    status     = ST_DONE;
    count_next = count;
    case (cmd.action)
      ACT_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (count == '0) begin
          status = ST_EMPTY;
        end else if (!found) begin
          status = ST_ABSENT;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: status = ST_DONE;
    endcase
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status         <= status;
      rsp.entry_count    <= count_ext[COUNT_W-1:0];
      rsp.smallest_value <= (count_next == '0) ? '0 : nxt[0];
    end
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import sit_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int MAX_PRINTS = 40;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Stimulus backlog and results still owed by the table
  cmd_t cmd_backlog[$];
  rsp_t rsp_expected[$];

  // Shadow copy of the sorted table
  logic signed [VALUE_W-1:0] held_vals [0:CAPACITY-1];
  int held_cnt = 0;

  int  err_cnt = 0;
  bit  no_idle = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;

  sorted_integer_table_top #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    if (err_cnt < MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  // Apply one insert or delete to the shadow table and return its response
  function automatic rsp_t apply_table_op(cmd_t c);
    rsp_t r;
    int pos;
    logic signed [VALUE_W-1:0] key;
    key = $signed(c.value);
    r.status = ST_DONE;
    pos = 0;
    if (c.action == ACT_INSERT) begin
      if (held_cnt >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        while (pos < held_cnt && held_vals[pos] < key) pos++;
        for (int k = held_cnt; k > pos; k--) held_vals[k] = held_vals[k-1];
        held_vals[pos] = key;
        held_cnt++;
      end
    end else begin
      if (held_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        while (pos < held_cnt && held_vals[pos] < key) pos++;
        if (pos >= held_cnt || held_vals[pos] != key) begin
          r.status = ST_ABSENT;
        end else begin
          for (int k = pos; k + 1 < held_cnt; k++) held_vals[k] = held_vals[k+1];
          held_cnt--;
        end
      end
    end
    r.entry_count = held_cnt[COUNT_W-1:0];
    r.smallest_value = (held_cnt > 0) ? held_vals[0] : '0;
    return r;
  endfunction

  task automatic queue_cmd(input logic act, input logic signed [VALUE_W-1:0] val);
    cmd_t c;
    c.action = act;
    c.value = val;
    cmd_backlog.push_back(c);
  endtask

  // Driver: presents queued commands with a random gap after each one
  always @(posedge clk) begin : driver
    cmd_t nxt;
    bit held;
    if (rst) begin
      cmd_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      held = cmd_valid && !cmd_ready;
      if (cmd_valid && cmd_ready) begin
        rsp_expected.push_back(apply_table_op(cmd));
      end
      if (!held) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          cmd_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          nxt = cmd_backlog.pop_front();
          cmd <= nxt;
          cmd_valid <= 1'b1;
          gap_left <= no_idle ? 0 : $urandom_range(0, 4);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each response transaction and stalls ready at random
  always @(posedge clk) begin : monitor
    rsp_t want;
    int n;
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_expected.size() == 0) begin
          report($sformatf("unexpected response %p", rsp));
        end else begin
          want = rsp_expected.pop_front();
          if (rsp.status !== want.status)
            report($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.entry_count !== want.entry_count)
            report($sformatf("entry_count got %0d want %0d",
                             rsp.entry_count, want.entry_count));
          if (rsp.smallest_value !== want.smallest_value)
            report($sformatf("smallest_value got %0d want %0d",
                             rsp.smallest_value, want.smallest_value));
        end
        n = no_idle ? 0 : $urandom_range(0, 4);
        rsp_ready <= (n == 0);
        stall_left <= (n > 0) ? n - 1 : 0;
      end else if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corner cases, then phases of biased random traffic
  initial begin : stimulus
    logic signed [VALUE_W-1:0] pool [0:7];
    int ins_pct;
    logic act;
    logic signed [VALUE_W-1:0] val;

    // empty table, extremes, duplicates, absent values
    queue_cmd(ACT_DELETE, 32'sd7);
    queue_cmd(ACT_INSERT, VAL_MAX);
    queue_cmd(ACT_INSERT, VAL_MIN);
    queue_cmd(ACT_INSERT, 32'sd0);
    queue_cmd(ACT_INSERT, 32'sd0);
    queue_cmd(ACT_DELETE, 32'sd5);
    queue_cmd(ACT_DELETE, 32'sd0);
    // fill to capacity, then one insert too many
    for (int i = 0; i < CAPACITY - 3; i++) queue_cmd(ACT_INSERT, $signed(i * 3 - 20));
    queue_cmd(ACT_INSERT, 32'sd1);
    queue_cmd(ACT_DELETE, VAL_MAX);
    queue_cmd(ACT_DELETE, VAL_MIN);
    queue_cmd(ACT_DELETE, VAL_MAX);
    queue_cmd(ACT_DELETE, -32'sd1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // hold the sender until the table has answered everything
    while (cmd_backlog.size() > 0 || cmd_valid || rsp_expected.size() > 0)
      @(posedge clk);

    for (int ph = 0; ph < 13; ph++) begin
      ins_pct = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 25 : 55;
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < 5; i++) pool[i] = $urandom;
      pool[5] = pool[4] + 1;
      pool[6] = VAL_MIN;
      pool[7] = VAL_MAX;
      for (int i = 0; i < 100; i++) begin
        act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_DELETE;
        if ($urandom_range(0, 15) == 0) val = $urandom;
        else val = pool[$urandom_range(0, 7)];
        queue_cmd(act, val);
      end
      while (cmd_backlog.size() > 0 || cmd_valid || rsp_expected.size() > 0)
        @(posedge clk);
    end

    // drain: wait for stray responses
    repeat (10) @(posedge clk);
    if (rsp_expected.size() > 0)
      report($sformatf("%0d responses never arrived", rsp_expected.size()));

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
